>>> rtl/miller_rabin_witness_test_top_defines.svh
// assertion macros for the witness test block
`ifndef MILLER_RABIN_WITNESS_TEST_TOP_DEFINES_SVH
`define MILLER_RABIN_WITNESS_TEST_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MRW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define MRW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MRW_ASSERT(lbl, prop)
`define MRW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/mrw_pkg.sv
// package for the witness test block: default width and sequencer states
package mrw_pkg;
	localparam int NUM_BITS_DEF = 31;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SPLIT,
		ST_PCHK,
		ST_PMUL,
		ST_PSQR,
		ST_YCHK,
		ST_YLOOP,
		ST_YSQR,
		ST_DONE
	} state_t;
endpackage

>>> rtl/miller_rabin_witness_test_top.sv
// strong probable prime test of one candidate against one base, bit-serial modular multiplier
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  input    | in_valid, in_stall | candidate, witness
//  output   | out_valid,out_stall| probable_prime
//
// each modular multiply takes one multiplier bit per cycle
// every modular multiply of an item runs on that one shared multiplier
// an even candidate or candidate one goes straight from idle to done, with no multiply
// arst_n clears the sequencer and the output beat; no clearing pass
// a new beat is taken once the previous result sits in the output register
`include "miller_rabin_witness_test_top_defines.svh"

module miller_rabin_witness_test_top #(
	parameter int NUM_BITS = mrw_pkg::NUM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [NUM_BITS-1:0] candidate,
	input  logic [NUM_BITS-1:0] witness,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                probable_prime
);
	localparam int CW = $clog2(NUM_BITS);

	mrw_pkg::state_t state_q, state_d;

	logic [NUM_BITS-1:0] n_q, m_q, acc_q, base_q;
	logic [NUM_BITS-1:0] mx_q, my_q, mr_q;
	logic [CW-1:0]       cnt_q, t_q, k_q;
	logic                res_q, out_valid_q, out_res_q;

	logic [NUM_BITS:0]   d, d1, s, s1, nw;
	logic [NUM_BITS-1:0] mm_res, nm1;
	logic                fin, ld, out_free;
	logic [NUM_BITS-1:0] ld_x, ld_y;
	logic                mul_op, mul_any;

	assign nm1      = n_q - NUM_BITS'(1);
	assign nw       = {1'b0, n_q};
	assign fin      = (cnt_q == CW'(NUM_BITS - 1));
	assign out_free = !out_valid_q || !out_stall;
	assign mul_op   = (state_q == mrw_pkg::ST_PMUL || state_q == mrw_pkg::ST_PSQR ||
		state_q == mrw_pkg::ST_YSQR);
	assign mul_any  = mul_op || (state_q == mrw_pkg::ST_REDUCE);

	// one interleaved step: double, reduce, add multiplicand, reduce
	always_comb begin
		d      = {mr_q, 1'b0};
		d1     = (d >= nw) ? d - nw : d;
		s      = d1 + (my_q[NUM_BITS-1] ? {1'b0, mx_q} : '0);
		s1     = (s >= nw) ? s - nw : s;
		mm_res = s1[NUM_BITS-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mrw_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!candidate[0] || candidate == NUM_BITS'(1))
						state_d = mrw_pkg::ST_DONE;
					else
						state_d = mrw_pkg::ST_REDUCE;
				end
			end
			mrw_pkg::ST_REDUCE: begin
				if (fin)
					state_d = mrw_pkg::ST_SPLIT;
			end
			mrw_pkg::ST_SPLIT: begin
				if (m_q[0])
					state_d = mrw_pkg::ST_PCHK;
			end
			mrw_pkg::ST_PCHK: begin
				if (m_q == '0)
					state_d = mrw_pkg::ST_YCHK;
				else if (m_q[0])
					state_d = mrw_pkg::ST_PMUL;
				else
					state_d = mrw_pkg::ST_PSQR;
			end
			mrw_pkg::ST_PMUL: begin
				if (fin)
					state_d = mrw_pkg::ST_PSQR;
			end
			mrw_pkg::ST_PSQR: begin
				if (fin)
					state_d = mrw_pkg::ST_PCHK;
			end
			mrw_pkg::ST_YCHK: begin
				if (acc_q == NUM_BITS'(1) || acc_q == nm1)
					state_d = mrw_pkg::ST_DONE;
				else
					state_d = mrw_pkg::ST_YLOOP;
			end
			mrw_pkg::ST_YLOOP: begin
				if (k_q >= t_q)
					state_d = mrw_pkg::ST_DONE;
				else
					state_d = mrw_pkg::ST_YSQR;
			end
			mrw_pkg::ST_YSQR: begin
				if (fin) begin
					if (mm_res == nm1 || mm_res == NUM_BITS'(1))
						state_d = mrw_pkg::ST_DONE;
					else
						state_d = mrw_pkg::ST_YLOOP;
				end
			end
			mrw_pkg::ST_DONE: begin
				if (out_free)
					state_d = mrw_pkg::ST_IDLE;
			end
			default: state_d = mrw_pkg::ST_IDLE;
		endcase
	end

	// operand loading for the multiplier on entry to an operation state
	always_comb begin
		ld   = (state_d != state_q);
		ld_x = base_q;
		ld_y = base_q;
		unique case (state_d)
			mrw_pkg::ST_REDUCE: begin
				ld_x = NUM_BITS'(1);
				ld_y = witness;
			end
			mrw_pkg::ST_PMUL: begin
				ld_y = acc_q;
			end
			mrw_pkg::ST_PSQR: begin
				ld_y = base_q;
			end
			mrw_pkg::ST_YSQR: begin
				ld_x = acc_q;
				ld_y = acc_q;
			end
			default: ld = 1'b0;
		endcase
	end

	assign in_stall       = (state_q != mrw_pkg::ST_IDLE);
	assign out_valid      = out_valid_q;
	assign probable_prime = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrw_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			out_res_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (!out_stall)
				out_valid_q <= 1'b0;
			if (state_q == mrw_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				out_res_q   <= res_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			mx_q  <= ld_x;
			my_q  <= ld_y;
			mr_q  <= '0;
			cnt_q <= '0;
		end else begin
			my_q  <= {my_q[NUM_BITS-2:0], 1'b0};
			mr_q  <= mm_res;
			cnt_q <= cnt_q + CW'(1);
		end
		unique case (state_q)
			mrw_pkg::ST_IDLE: begin
				n_q   <= candidate;
				m_q   <= candidate - NUM_BITS'(1);
				acc_q <= NUM_BITS'(1);
				t_q   <= '0;
				res_q <= 1'b0;
			end
			mrw_pkg::ST_REDUCE: begin
				if (fin)
					base_q <= mm_res;
			end
			mrw_pkg::ST_SPLIT: begin
				if (!m_q[0]) begin
					m_q <= m_q >> 1;
					t_q <= t_q + CW'(1);
				end
			end
			mrw_pkg::ST_PMUL: begin
				if (fin)
					acc_q <= mm_res;
			end
			mrw_pkg::ST_PSQR: begin
				if (fin) begin
					base_q <= mm_res;
					m_q    <= m_q >> 1;
				end
			end
			mrw_pkg::ST_YCHK: begin
				k_q   <= CW'(1);
				res_q <= (acc_q == NUM_BITS'(1) || acc_q == nm1);
			end
			mrw_pkg::ST_YLOOP: begin
				res_q <= 1'b0;
			end
			mrw_pkg::ST_YSQR: begin
				if (fin) begin
					acc_q <= mm_res;
					k_q   <= k_q + CW'(1);
					res_q <= (mm_res == nm1);
				end
			end
			default: begin
			end
		endcase
	end

	`MRW_ASSERT(a_mx_reduced, !mul_op || mx_q < n_q)
	`MRW_ASSERT(a_mr_reduced, !mul_any || mr_q < n_q)
	`MRW_ASSERT_NEXT(a_even_fast, in_valid && !in_stall && !candidate[0], state_q == mrw_pkg::ST_DONE && !res_q)
	`MRW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(probable_prime))
endmodule
